// ----- rtl/point_ring_radius_search_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for point_ring_radius_search
// Short forms for same-cycle and next-cycle checks, reset masked.
// ----------------------------------------------------------------------------
`ifndef POINT_RING_RADIUS_SEARCH_MACROS_SVH
`define POINT_RING_RADIUS_SEARCH_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define PRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define PRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/prs_pkg.sv -----
// ----------------------------------------------------------------------------
// prs_pkg
// Shared constants, operation codes and ring addressing for the point ring.
// ----------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

    // Ring geometry
    localparam int CAPACITY    = 64;
    localparam int ADDR_BITS   = $clog2(CAPACITY);
    localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
    localparam int POS_BITS    = 6;

    // Point and distance widths
    localparam int COORD_BITS     = 16;
    localparam int POINT_BITS     = 3 * COORD_BITS;
    localparam int DIFF_BITS      = COORD_BITS + 1;
    localparam int PROD_BITS      = 2 * DIFF_BITS;
    localparam int SQ_BITS        = 2 * COORD_BITS;
    localparam int DIST_BITS      = SQ_BITS + 2;
    localparam int RADIUS_BITS    = 16;
    localparam int RADIUS_SQ_BITS = 2 * RADIUS_BITS;

    // Stream payload widths
    localparam int OP_BITS   = 2;
    localparam int IN_BITS   = OP_BITS + POINT_BITS + POS_BITS;
    localparam int IN_WIDTH  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 1 + POS_BITS + POINT_BITS + COUNT_BITS;
    localparam int OUT_WIDTH = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_FIND  = 2'd2,
        OP_GET   = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_FIND = 5'b00010,
        ST_GET  = 5'b00100,
        ST_RESP = 5'b01000,
        ST_HOLD = 5'b10000
    } state_t;

    // Physical slot of a logical position: both inputs are below CAPACITY
    function automatic logic [ADDR_BITS-1:0] ring_addr(
        input logic [ADDR_BITS-1:0] oldest,
        input logic [ADDR_BITS-1:0] logical
    );
        logic [ADDR_BITS:0] sum;
        sum = {1'b0, oldest} + {1'b0, logical};
        if (sum >= (ADDR_BITS + 1)'(CAPACITY)) begin
            sum = sum - (ADDR_BITS + 1)'(CAPACITY);
        end
        return sum[ADDR_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/point_ring_radius_search.sv -----
// ----------------------------------------------------------------------------
// point_ring_radius_search
// Ring of the last 64 three-axis points with first-match radius search.
//
// Each input transfer carries one operation and yields exactly one result
// transfer. Add stores the point at the head slot and advances the head;
// clear empties the ring; get returns the point at a logical position
// (0 = oldest) or zeros with hit low when the position is not held; find
// scans from a logical position toward the newest point and returns the
// first one whose squared distance to the probe is at most match_radius
// squared. Points sit in one 48-bit wide memory with a single read port,
// which find walks one point per cycle through a read, square and compare
// pipeline. The next input transfer is taken while a result still waits on
// m_tready. match_radius is written by cfg_we/cfg_wdata; the user must
// write it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none
`include "point_ring_radius_search_macros.svh"

module point_ring_radius_search (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration: match_radius
    input  wire logic                          cfg_we,
    input  wire logic [prs_pkg::RADIUS_BITS-1:0] cfg_wdata,
    // Input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata, low bit up: operation[2], probe_x[16], probe_y[16], probe_z[16],
    // logical_position[6]
    input  wire logic [prs_pkg::IN_WIDTH-1:0]  s_tdata,
    // Result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata, low bit up: hit[1], hit_position[6], point_x[16], point_y[16],
    // point_z[16], point_count[7], zero pad[2]
    output logic [prs_pkg::OUT_WIDTH-1:0]      m_tdata
);

    import prs_pkg::*;

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    state_t                     state_reg, state_next;
    logic [ADDR_BITS-1:0]       slot_reg;
    logic [COUNT_BITS-1:0]      count_reg;
    logic [RADIUS_SQ_BITS-1:0]  radius_sq_reg, radius_sq_next;

    logic signed [COORD_BITS-1:0] probe_x_reg, probe_y_reg, probe_z_reg;

    logic [COUNT_BITS-1:0]      scan_idx_reg;
    logic                       rd_valid_reg;
    logic [COUNT_BITS-1:0]      rd_idx_reg;
    logic                       sq_valid_reg;
    logic [COUNT_BITS-1:0]      sq_idx_reg;
    logic [SQ_BITS-1:0]         sq_x_reg, sq_y_reg, sq_z_reg;

    logic                       res_hit_reg;
    logic [POS_BITS-1:0]        res_pos_reg;
    logic [POINT_BITS-1:0]      res_point_reg;

    logic                       m_tvalid_reg;
    logic [OUT_WIDTH-1:0]       m_tdata_reg;

    op_t                        in_op;
    logic signed [COORD_BITS-1:0] in_x, in_y, in_z;
    logic [POS_BITS-1:0]        in_pos;
    logic                       accept;
    logic                       full;
    logic                       get_valid;
    logic [ADDR_BITS-1:0]       oldest;

    logic                       ram_we, ram_re;
    logic [ADDR_BITS-1:0]       ram_waddr, ram_raddr;
    logic [POINT_BITS-1:0]      ram_wdata, ram_rdata;

    logic                       issue;
    logic signed [COORD_BITS-1:0] rd_x, rd_y, rd_z;
    logic signed [DIFF_BITS-1:0]  dx, dy, dz;
    logic signed [PROD_BITS-1:0]  px, py, pz;
    logic [DIST_BITS-1:0]       dist_sum;
    logic                       match;
    logic                       drained;
    logic                       find_done;
    logic                       out_free;

    // ------------------------------------------------------------------
    // Input unpacking and handshake
    // ------------------------------------------------------------------
    assign in_op  = op_t'(s_tdata[OP_BITS-1:0]);
    assign in_x   = s_tdata[OP_BITS +: COORD_BITS];
    assign in_y   = s_tdata[OP_BITS + COORD_BITS +: COORD_BITS];
    assign in_z   = s_tdata[OP_BITS + 2 * COORD_BITS +: COORD_BITS];
    assign in_pos = s_tdata[OP_BITS + POINT_BITS +: POS_BITS];

    // No transfer is taken while reset is held
    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign full      = (count_reg == COUNT_BITS'(CAPACITY));
    assign oldest    = full ? slot_reg : '0;
    assign get_valid = (COUNT_BITS'(in_pos) < count_reg);

    // ------------------------------------------------------------------
    // Point memory: writes only on an accepted add, reads only in a find
    // scan or on an accepted get, so the two ports never meet on one entry
    // ------------------------------------------------------------------
    assign issue = (state_reg == ST_FIND) && (scan_idx_reg < count_reg);

    assign ram_we    = accept && (in_op == OP_ADD);
    assign ram_waddr = slot_reg;
    assign ram_wdata = {in_z, in_y, in_x};
    assign ram_re    = issue || (accept && (in_op == OP_GET));
    assign ram_raddr = (state_reg == ST_FIND)
                     ? ring_addr(oldest, ADDR_BITS'(scan_idx_reg))
                     : ring_addr(oldest, ADDR_BITS'(in_pos));

    prs_ram #(
        .WIDTH (POINT_BITS),
        .DEPTH (CAPACITY)
    ) u_point_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Distance pipeline: squares after the read, sum and compare after that
    // ------------------------------------------------------------------
    assign rd_x = ram_rdata[0 +: COORD_BITS];
    assign rd_y = ram_rdata[COORD_BITS +: COORD_BITS];
    assign rd_z = ram_rdata[2 * COORD_BITS +: COORD_BITS];

    assign dx = DIFF_BITS'(rd_x) - DIFF_BITS'(probe_x_reg);
    assign dy = DIFF_BITS'(rd_y) - DIFF_BITS'(probe_y_reg);
    assign dz = DIFF_BITS'(rd_z) - DIFF_BITS'(probe_z_reg);

    assign px = dx * dx;
    assign py = dy * dy;
    assign pz = dz * dz;

    // Exact: three squares below 2^32 each
    assign dist_sum = DIST_BITS'(sq_x_reg) + DIST_BITS'(sq_y_reg)
                    + DIST_BITS'(sq_z_reg);
    assign match    = sq_valid_reg && (dist_sum <= DIST_BITS'(radius_sq_reg));

    assign drained   = !issue && !rd_valid_reg && !sq_valid_reg;
    assign find_done = (state_reg == ST_FIND) && (match || drained);

    assign radius_sq_next = RADIUS_SQ_BITS'(cfg_wdata) * RADIUS_SQ_BITS'(cfg_wdata);

    assign out_free = !m_tvalid_reg || m_tready;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_op)
                        OP_FIND: state_next = ST_FIND;
                        OP_GET:  state_next = ST_GET;
                        default: state_next = ST_RESP;
                    endcase
                end
            end
            ST_FIND: begin
                if (find_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_GET:  state_next = ST_RESP;
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            count_reg     <= '0;
            radius_sq_reg <= '0;
            rd_valid_reg  <= 1'b0;
            sq_valid_reg  <= 1'b0;
            scan_idx_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                radius_sq_reg <= radius_sq_next;
            end

            // Ring head and fill level
            if (accept) begin
                case (in_op)
                    OP_ADD: begin
                        slot_reg <= (slot_reg == ADDR_BITS'(CAPACITY - 1))
                                  ? '0 : slot_reg + 1'b1;
                        if (!full) begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        slot_reg  <= '0;
                        count_reg <= '0;
                    end
                    default: ;
                endcase
            end

            // Scan index and in-flight markers, dropped once the find ends
            if (accept) begin
                scan_idx_reg <= COUNT_BITS'(in_pos);
            end else if (issue) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            rd_valid_reg <= issue && !find_done;
            sq_valid_reg <= rd_valid_reg && !find_done;

            // Output register
            if ((state_reg == ST_RESP || state_reg == ST_HOLD) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            probe_x_reg   <= in_x;
            probe_y_reg   <= in_y;
            probe_z_reg   <= in_z;
            res_hit_reg   <= (in_op == OP_GET) && get_valid;
            res_pos_reg   <= '0;
            res_point_reg <= '0;
        end

        // Get: latch the point read in the accept cycle
        if (state_reg == ST_GET && res_hit_reg) begin
            res_point_reg <= ram_rdata;
        end

        // Find: first match in scan order
        if (state_reg == ST_FIND && match) begin
            res_hit_reg <= 1'b1;
            res_pos_reg <= POS_BITS'(sq_idx_reg);
        end

        rd_idx_reg <= scan_idx_reg;
        sq_idx_reg <= rd_idx_reg;
        sq_x_reg   <= px[SQ_BITS-1:0];
        sq_y_reg   <= py[SQ_BITS-1:0];
        sq_z_reg   <= pz[SQ_BITS-1:0];

        if ((state_reg == ST_RESP || state_reg == ST_HOLD) && out_free) begin
            m_tdata_reg <= OUT_WIDTH'({count_reg, res_point_reg, res_pos_reg, res_hit_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PRS_ASSERT_NOW(a_ram_ports, ram_we, !ram_re, "point memory read and write in one cycle")
    `PRS_ASSERT_NOW(a_count_range, 1'b1, count_reg <= COUNT_BITS'(CAPACITY), "fill level beyond capacity")
    `PRS_ASSERT_NEXT(a_add_count, accept && (in_op == OP_ADD) && !full, count_reg == $past(count_reg) + 1'b1, "add did not raise fill level")
    `PRS_ASSERT_NOW(a_hit_held, (state_reg == ST_RESP) && res_hit_reg, COUNT_BITS'(res_pos_reg) < count_reg, "hit position not held")

endmodule

`default_nettype wire

// ----- rtl/prs_ram.sv -----
// ----------------------------------------------------------------------------
// prs_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_ram #(
    parameter  int WIDTH = 48,
    parameter  int DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
